// File: src/ptt_pkg.sv
// Package for the periodic timer table: request and status codes, sequencer
// states, the stored row layout and the types of the shared compare unit.
// Depends on nothing; every other file imports it.
`default_nettype none

package ptt_pkg;

  localparam int KEY_W    = 16;
  localparam int PERIOD_W = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_MODIFY = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_SEARCH,
    S_EMIT,
    S_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    ALU_MATCH,
    ALU_EXPIRE,
    ALU_LESS
  } alu_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] elapsed;
  } row_t;

  typedef struct packed {
    alu_op_t          op;
    row_t             row;
    logic [KEY_W-1:0] ref_key;
  } alu_in_t;

  typedef struct packed {
    logic                flag;
    logic [PERIOD_W-1:0] elapsed_inc;
  } alu_res_t;

endpackage

`default_nettype wire

// File: src/periodic_timer_table.sv
// Top level of the periodic timer table: sequencer, entry memory, valid and
// expiry flags, and the result register.
// Depends on ptt_pkg and ptt_alu.
`default_nettype none

// A table of TABLE_DEPTH keyed periodic timers held in a single-port-read
// entry memory, walked one entry per cycle by a small sequencer around one
// shared compare unit. One item is taken at a time. A result waits until the
// result register is free. A tick puts the expired keys out in ascending
// order, by one full pass over the memory per key. No clearing pass is
// needed after reset; the valid flags reset to zero. The result register lets
// a new item be accepted while the last result still waits to be taken.
module periodic_timer_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] timer_key, [47:16] period
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [17:2] expired_key, rest zero
  output logic [0:0]  out_tuser,  // [0] fired
  output logic        out_tlast
);
  import ptt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;

  logic [CW-1:0] idx_r, idx_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] pidx_r;

  logic          found_r, found_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  row_t          keep_r, keep_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_slot_r, free_slot_nxt;

  logic             best_found_r, best_found_nxt;
  logic [KEY_W-1:0] best_key_r, best_key_nxt;
  logic [IW-1:0]    best_slot_r, best_slot_nxt;

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] hit_r, hit_nxt;
  logic [CW-1:0]          hit_cnt_r, hit_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_fired_r, out_fired_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic             out_last_r, out_last_nxt;

  row_t          mem [TABLE_DEPTH];
  row_t          rd_row_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  row_t          wr_row;

  alu_in_t  alu_in;
  alu_res_t alu_res;

  logic scan_issue;
  logic scan_done;
  logic out_free;
  logic ent_valid;

  ptt_alu u_alu (
    .alu_in  (alu_in),
    .alu_res (alu_res)
  );

  assign scan_issue = (idx_r < CW'(TABLE_DEPTH));
  assign scan_done  = !scan_issue && !pv_r;
  assign out_free   = !out_valid_r || out_tready;
  assign ent_valid  = valid_r[pidx_r];
  assign rd_addr    = idx_r[IW-1:0];

  always_comb begin
    alu_in.row     = rd_row_r;
    alu_in.ref_key = (state_r == S_SEARCH) ? best_key_r : key_r;
    unique case (state_r)
      S_SCAN:  alu_in.op = ALU_MATCH;
      S_WALK:  alu_in.op = ALU_EXPIRE;
      default: alu_in.op = ALU_LESS;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    per_nxt        = per_r;
    idx_nxt        = idx_r;
    pv_nxt         = 1'b0;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    keep_nxt       = keep_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    best_found_nxt = best_found_r;
    best_key_nxt   = best_key_r;
    best_slot_nxt  = best_slot_r;
    valid_nxt      = valid_r;
    hit_nxt        = hit_r;
    hit_cnt_nxt    = hit_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_key_nxt    = out_key_r;
    out_last_nxt   = out_last_r;
    in_tready      = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = pidx_r;
    wr_row         = rd_row_r;

    // The three walking states share one read pipeline: the address goes
    // out in one cycle and the row is handled in the next.
    if (state_r == S_SCAN || state_r == S_WALK || state_r == S_SEARCH) begin
      rd_en = scan_issue;
      pv_nxt = scan_issue;
      if (scan_issue) begin
        idx_nxt = idx_r + CW'(1);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          req_nxt        = req_t'(in_tuser);
          key_nxt        = in_tdata[15:0];
          per_nxt        = in_tdata[47:16];
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          best_found_nxt = 1'b0;
          hit_cnt_nxt    = '0;
          state_nxt      = (req_t'(in_tuser) == REQ_TICK) ? S_WALK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (pv_r) begin
          if (ent_valid && alu_res.flag) begin
            found_nxt = 1'b1;
            slot_nxt  = pidx_r;
            keep_nxt  = rd_row_r;
          end
          if (!ent_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = pidx_r;
          end
        end
        if (scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_WALK: begin
        if (pv_r) begin
          hit_nxt[pidx_r] = ent_valid && alu_res.flag;
          if (ent_valid) begin
            wr_en          = 1'b1;
            wr_row.elapsed = alu_res.flag ? '0 : alu_res.elapsed_inc;
            hit_cnt_nxt    = hit_cnt_r + CW'(alu_res.flag);
          end
        end
        if (scan_done) begin
          idx_nxt   = '0;
          state_nxt = (hit_cnt_r == '0) ? S_COMMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Keys in the table are unique, so a strict compare picks one slot.
        if (pv_r && hit_r[pidx_r] && (!best_found_r || alu_res.flag)) begin
          best_found_nxt = 1'b1;
          best_key_nxt   = rd_row_r.key;
          best_slot_nxt  = pidx_r;
        end
        if (scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_status_nxt        = STAT_OK;
          out_fired_nxt         = 1'b1;
          out_key_nxt           = best_key_r;
          out_last_nxt          = (hit_cnt_r == CW'(1));
          hit_nxt[best_slot_r]  = 1'b0;
          hit_cnt_nxt           = hit_cnt_r - CW'(1);
          idx_nxt               = '0;
          best_found_nxt        = 1'b0;
          state_nxt             = (hit_cnt_r == CW'(1)) ? S_IDLE : S_SEARCH;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = 1'b0;
          out_key_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STAT_OK;
          state_nxt      = S_IDLE;
          unique case (req_r)
            REQ_ADD: begin
              if (found_r) begin
                out_status_nxt = STAT_REJECT;
              end else if (!free_found_r) begin
                out_status_nxt = STAT_FULL;
              end else begin
                wr_en                  = 1'b1;
                wr_addr                = free_slot_r;
                wr_row.key             = key_r;
                wr_row.period          = per_r;
                wr_row.elapsed         = '0;
                valid_nxt[free_slot_r] = 1'b1;
              end
            end
            REQ_DELETE: begin
              if (found_r) begin
                valid_nxt[slot_r] = 1'b0;
              end else begin
                out_status_nxt = STAT_REJECT;
              end
            end
            REQ_MODIFY: begin
              if (found_r) begin
                wr_en         = 1'b1;
                wr_addr       = slot_r;
                wr_row        = keep_r;
                wr_row.period = per_r;
              end else begin
                out_status_nxt = STAT_REJECT;
              end
            end
            default: begin
              // A tick in which no timer expired.
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= 1'b0;
      valid_r     <= '0;
      hit_r       <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      valid_r     <= valid_nxt;
      hit_r       <= hit_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    per_r        <= per_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= idx_r[IW-1:0];
    found_r      <= found_nxt;
    slot_r       <= slot_nxt;
    keep_r       <= keep_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    best_found_r <= best_found_nxt;
    best_key_r   <= best_key_nxt;
    best_slot_r  <= best_slot_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {6'd0, out_key_r, out_status_r};
  assign out_tuser[0] = out_fired_r;
  assign out_tlast    = out_last_r;

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_EMIT) |-> hit_cnt_r == $countones(hit_r))
    else $error("expired count disagrees with expiry flags");

  a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> hit_r == '0)
    else $error("expiry flags left set after a tick");

  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> best_found_r)
    else $error("search pass ended without an expired timer");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata[1:0] == STAT_OK)
    else $error("expired timer reported with a bad status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new item taken while the previous one is in work");

endmodule

`default_nettype wire

// File: src/ptt_alu.sv
// Shared compare unit of the timer table: one magnitude comparator serves the
// key lookup, the expiry test and the smallest-key search.
// Depends on ptt_pkg.
`default_nettype none

module ptt_alu (
  input  ptt_pkg::alu_in_t  alu_in,
  output ptt_pkg::alu_res_t alu_res
);
  import ptt_pkg::*;

  logic [PERIOD_W-1:0] inc;
  logic [PERIOD_W-1:0] opa;
  logic [PERIOD_W-1:0] opb;
  logic                lt;
  logic                eq;

  // The elapsed count saturates at all ones.
  assign inc = (alu_in.row.elapsed == '1) ? alu_in.row.elapsed
                                          : alu_in.row.elapsed + PERIOD_W'(1);

  always_comb begin
    unique case (alu_in.op)
      ALU_EXPIRE: begin
        opa = inc;
        opb = alu_in.row.period;
      end
      default: begin
        opa = PERIOD_W'(alu_in.row.key);
        opb = PERIOD_W'(alu_in.ref_key);
      end
    endcase
  end

  assign lt = (opa < opb);
  assign eq = (opa == opb);

  always_comb begin
    alu_res.elapsed_inc = inc;
    unique case (alu_in.op)
      ALU_MATCH:  alu_res.flag = eq;
      ALU_EXPIRE: alu_res.flag = !lt;
      ALU_LESS:   alu_res.flag = lt;
      default:    alu_res.flag = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: bench/periodic_timer_table_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_timer_table: directed and random timer requests,
// with results predicted from a shadow copy of the timer table. Depends on ptt_pkg.

module periodic_timer_table_tb;
  import ptt_pkg::*;

  localparam int DEPTH          = 16;
  localparam int IDLE_PCT       = 38;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int KEY_POOL       = 24;
  localparam int STALL_CYCLES   = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [15:0] key;
    logic        last;
  } timer_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // [15:0] timer_key, [47:16] period
  logic [1:0]  in_tuser   = '0;  // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [1:0] status, [17:2] expired_key, rest zero
  logic [0:0]  out_tuser;        // [0] fired
  logic        out_tlast;

  // Shadow copy of the timer table.
  logic        slot_used    [DEPTH];
  logic [15:0] slot_key     [DEPTH];
  logic [31:0] slot_period  [DEPTH];
  logic [31:0] slot_elapsed [DEPTH];

  timer_result_t pending_results[$];
  logic [15:0]   key_pool[KEY_POOL];

  int error_count  = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  int hold_left    = 0;
  bit no_idle      = 1'b0;

  periodic_timer_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void predict_request(req_t req, logic [15:0] key, logic [31:0] per);
    timer_result_t res;
    logic          expired[DEPTH];
    int            n_fired;
    int            best;
    int            match;
    int            free_slot;
    res.status = STAT_OK;
    res.fired  = 1'b0;
    res.key    = '0;
    res.last   = 1'b1;
    if (req == REQ_TICK) begin
      for (int i = 0; i < DEPTH; i++) begin
        expired[i] = 1'b0;
        if (slot_used[i]) begin
          if (slot_elapsed[i] != '1)
            slot_elapsed[i] = slot_elapsed[i] + 1;
          if (slot_period[i] <= slot_elapsed[i]) begin
            expired[i]      = 1'b1;
            slot_elapsed[i] = '0;
          end
        end
      end
      // Expired keys come out smallest first, regardless of slot order.
      n_fired = 0;
      do begin
        best = -1;
        for (int i = 0; i < DEPTH; i++)
          if (expired[i] && (best < 0 || slot_key[i] < slot_key[best]))
            best = i;
        if (best >= 0) begin
          expired[best] = 1'b0;
          res.fired     = 1'b1;
          res.key       = slot_key[best];
          res.last      = 1'b0;
          pending_results.push_back(res);
          n_fired++;
        end
      end while (best >= 0);
      if (n_fired == 0)
        pending_results.push_back(res);
      else
        pending_results[pending_results.size() - 1].last = 1'b1;
      return;
    end
    match = -1;
    for (int i = 0; i < DEPTH; i++)
      if (match < 0 && slot_used[i] && slot_key[i] == key)
        match = i;
    if (req == REQ_ADD) begin
      free_slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (free_slot < 0 && !slot_used[i])
          free_slot = i;
      if (match >= 0) begin
        res.status = STAT_REJECT;
      end else if (free_slot < 0) begin
        res.status = STAT_FULL;
      end else begin
        slot_used[free_slot]    = 1'b1;
        slot_key[free_slot]     = key;
        slot_period[free_slot]  = per;
        slot_elapsed[free_slot] = '0;
      end
    end else if (match < 0) begin
      res.status = STAT_REJECT;
    end else if (req == REQ_DELETE) begin
      slot_used[match] = 1'b0;
    end else begin
      slot_period[match] = per;
    end
    pending_results.push_back(res);
  endfunction

  task automatic send_request(req_t req, logic [15:0] key, logic [31:0] per);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {per, key};
    do @(posedge clk); while (!in_tready);
    predict_request(req, key, per);
  endtask

  function automatic logic [31:0] random_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 32'($urandom_range(0, 4));
    else if (r < 85)
      return 32'($urandom_range(5, 20));
    return $urandom;
  endfunction

  // Mostly keys from a small pool or already in the table, so that adds collide
  // and deletes and modifies hit; the rest are arbitrary and nearly always absent.
  function automatic logic [15:0] pick_key();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, DEPTH - 1);
    if (r < 65)
      return key_pool[$urandom_range(0, KEY_POOL - 1)];
    else if (r < 85 && slot_used[s])
      return slot_key[s];
    return 16'($urandom);
  endfunction

  task automatic test_empty_table();
    send_request(REQ_TICK, 16'h0000, 32'h0000_0000);
    send_request(REQ_DELETE, 16'h1234, 32'h0000_0001);
    send_request(REQ_MODIFY, 16'hABCD, 32'h0000_0002);
  endtask

  task automatic test_key_extremes();
    send_request(REQ_ADD, 16'h0000, 32'h0000_0000);
    send_request(REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 16'h0000, 32'h0000_0005);
    send_request(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_table();
    // Descending keys, so the expiry order is the reverse of the slot order.
    for (int i = 0; i < DEPTH - 2; i++)
      send_request(REQ_ADD, 16'(16'hC000 - i * 16'h0421), 32'(i % 3));
    send_request(REQ_ADD, 16'h5A5A, 32'h0000_0001);
    send_request(REQ_TICK, 16'h0000, 32'h0000_0000);
    send_request(REQ_MODIFY, 16'hFFFF, 32'h0000_0000);
    send_request(REQ_DELETE, 16'h0000, 32'h0000_0000);
    send_request(REQ_ADD, 16'h0001, 32'h0000_0002);
    send_request(REQ_TICK, 16'h0000, 32'h0000_0000);
  endtask

  task automatic test_random_traffic(int count);
    int   r;
    req_t req;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_request(req_t'($urandom_range(0, 3)), 16'($urandom), $urandom);
      end else begin
        if (r < 40)
          req = REQ_TICK;
        else if (r < 68)
          req = REQ_ADD;
        else if (r < 82)
          req = REQ_DELETE;
        else
          req = REQ_MODIFY;
        send_request(req, pick_key(), random_period());
      end
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(40);
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_request = STALL_CYCLES;
    test_random_traffic(10);
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: tdata=%h fired=%b last=%b",
               out_tdata, out_tuser[0], out_tlast);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
          error_count++;
        end
        if (out_tuser[0] !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, out_tuser[0]);
          error_count++;
        end
        if (out_tdata[17:2] !== want.key) begin
          $error("expired_key: expected %h, got %h", want.key, out_tdata[17:2]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_timer_table regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i]    = 1'b0;
      slot_key[i]     = '0;
      slot_period[i]  = '0;
      slot_elapsed[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++)
      key_pool[i] = 16'($urandom);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_key_extremes();
    test_full_table();
    test_random_traffic(100);
    test_back_to_back();
    test_output_stall();
    test_random_traffic(90);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("periodic_timer_table regression: pass");
    else
      $display("periodic_timer_table regression: fail");
    $finish;
  end

endmodule
